// ===== hdl/b2d_pkg.sv =====
package b2d_pkg;

	localparam int VALUE_W    = 32;
	localparam int NUM_DIGITS = 10;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int BIT_CNT_W  = $clog2(VALUE_W);
	localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);
	localparam int CHAR_W     = 6;

	localparam logic [BIT_CNT_W-1:0] LAST_BIT  = BIT_CNT_W'(VALUE_W - 1);
	localparam logic [CHAR_W-1:0]    ASCII_ZERO = 6'd48;

	// Status of the bit-serial converter as seen by the sequencer.
	typedef struct packed {
		logic active;
		logic finish;
	} dab_stat_t;

	// One result on its way to the ports.
	typedef struct packed {
		logic              strobe;
		logic              last;
		logic [CHAR_W-1:0] code;
	} res_t;

endpackage

// ===== hdl/b2d_dabble.sv =====
module b2d_dabble (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [b2d_pkg::VALUE_W-1:0]   value,
	output b2d_pkg::dab_stat_t            stat,
	output logic [b2d_pkg::BCD_W-1:0]     bcd_next
);
	import b2d_pkg::*;

	logic [VALUE_W-1:0]   shift_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BCD_W-1:0]     bcd_adj;
	logic [BIT_CNT_W-1:0] cnt_q;
	logic                 active_q;

	// Each digit of five or more gets three added before the shift doubles it.
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	assign bcd_next    = {bcd_adj[BCD_W-2:0], shift_q[VALUE_W-1]};
	assign stat.active = active_q;
	assign stat.finish = active_q && (cnt_q == LAST_BIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (active_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_BIT) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= value;
			bcd_q   <= '0;
		end else if (active_q) begin
			shift_q <= {shift_q[VALUE_W-2:0], 1'b0};
			bcd_q   <= bcd_next;
		end
	end

endmodule

// ===== hdl/b2d_emit.sv =====
module b2d_emit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic [b2d_pkg::BCD_W-1:0] bcd,
	output logic                      active,
	output b2d_pkg::res_t             res
);
	import b2d_pkg::*;

	logic [BCD_W-1:0]     bcd_q;
	logic [DIG_CNT_W-1:0] rem_q;
	logic                 active_q;
	logic                 leading_q;
	logic                 strobe_q;
	logic                 last_q;
	logic [CHAR_W-1:0]    code_q;
	logic [3:0]           top;
	logic                 one_left;
	logic                 skip;

	assign top      = bcd_q[BCD_W-1 -: 4];
	assign one_left = (rem_q == DIG_CNT_W'(1));
	// A leading zero is dropped, but the final digit is always sent.
	assign skip     = leading_q && (top == 4'd0) && !one_left;

	assign active     = active_q;
	assign res.strobe = strobe_q;
	assign res.last   = last_q;
	assign res.code   = code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			leading_q <= 1'b0;
			rem_q     <= '0;
			strobe_q  <= 1'b0;
		end else if (load) begin
			active_q  <= 1'b1;
			leading_q <= 1'b1;
			rem_q     <= DIG_CNT_W'(NUM_DIGITS);
			strobe_q  <= 1'b0;
		end else if (active_q) begin
			rem_q    <= rem_q - 1'b1;
			strobe_q <= !skip;
			if (!skip) begin
				leading_q <= 1'b0;
			end
			if (one_left) begin
				active_q <= 1'b0;
			end
		end else begin
			strobe_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bcd_q <= bcd;
		end else if (active_q) begin
			bcd_q  <= {bcd_q[BCD_W-5:0], 4'd0};
			code_q <= ASCII_ZERO + {2'b00, top};
			last_q <= one_left;
		end
	end

endmodule

// ===== hdl/binary_to_decimal_ascii_top.sv =====
// Channel   Direction  Signals                          Handshake
// request   in         value                            start high while busy is low
// result    out        digit_char, last_digit           strobe high for one cycle
//
// A request runs bit-serial shift-and-add-3 conversion, one input bit per
// cycle, and then steps through every decimal digit position, leading zeros
// included, before busy drops.
// Results appear one per cycle from the most significant nonzero digit on.
// Reset is asynchronous and active low; it clears all control state.
// The receiver cannot stall: each result is valid for exactly one cycle.
module binary_to_decimal_ascii_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [b2d_pkg::VALUE_W-1:0] value,
	output logic                        strobe,
	output logic [b2d_pkg::CHAR_W-1:0]  digit_char,
	output logic                        last_digit
);
	import b2d_pkg::*;

	dab_stat_t        dab_stat;
	logic [BCD_W-1:0] bcd_next;
	logic             emit_active;
	logic             accept;
	res_t             res;

	// A request is taken only when neither the converter nor the digit
	// emitter holds work, so the two never overlap.
	assign busy   = dab_stat.active || emit_active;
	assign accept = start && !busy;

	// The converter shifts the value into ten BCD digits, MSB first.
	b2d_dabble u_dabble (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.value    (value),
		.stat     (dab_stat),
		.bcd_next (bcd_next)
	);

	// The emitter takes the finished BCD word on the converter's last shift,
	// so no cycle is lost between the two phases.
	b2d_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (dab_stat.finish),
		.bcd    (bcd_next),
		.active (emit_active),
		.res    (res)
	);

	assign strobe     = res.strobe;
	assign digit_char = res.code;
	assign last_digit = res.last;

endmodule
